// File: rtl/core/pfr_pkg.sv
// pfr_pkg: shared types, codes and helpers for the page frame replacement block
// item structs for the reference and result channels, register indexes, policy codes
// no dependencies
package pfr_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_FRAMES_DEF = 64;
    localparam int MAX_PROCS_DEF  = 8;

    // fixed field widths
    localparam int PID_IN_W = 3;
    localparam int WORD_W   = 16;
    localparam int RND_W    = 31;
    localparam int CNT_W32  = 32;
    localparam int CFG_W    = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_FRAMES = 2'd1;
    localparam logic [1:0] CFG_PAGE   = 2'd2;

    // replacement policy codes (any other code evicts frame 0)
    localparam logic [1:0] POL_RANDOM = 2'd0;
    localparam logic [1:0] POL_LAST   = 2'd1;
    localparam logic [1:0] POL_LRU    = 2'd2;

    // register reset values
    localparam logic [1:0]  POLICY_RST     = POL_LRU;
    localparam logic [6:0]  FRAMES_RST     = 7'd64;
    localparam logic [15:0] PAGE_WORDS_RST = 16'd16;

    // one memory reference
    typedef struct packed {
        logic [2:0]  process_id;
        logic [15:0] word_address;
        logic [30:0] random_value;
    } ref_item_t;

    // one result item
    typedef struct packed {
        logic        hit;
        logic [5:0]  frame_used;
        logic        evicted;
        logic [2:0]  victim_process;
        logic [15:0] victim_page;
        logic [31:0] victim_residency;
        logic [31:0] requester_faults;
        logic [31:0] victim_evictions;
        logic [31:0] victim_residency_total;
    } result_item_t;

    // sequencer to frame table control
    typedef struct packed {
        logic start;
        logic use_lru;
        logic fill;
    } scan_ctrl_t;

    // frame table status back to the sequencer
    typedef struct packed {
        logic clear_busy;
        logic done;
        logic hit;
        logic free_found;
    } scan_stat_t;

    // saturating 32-bit add
    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // process number folded below the process count, by repeated subtract
    function automatic logic [2:0] pid_wrap(logic [2:0] v, int unsigned m);
        logic [3:0] r;
        r = {1'b0, v};
        for (int k = 0; k < 8; k++) begin
            if (int'(r) >= m)
            begin
                r = r - 4'(m);
            end
        end
        return r[2:0];
    endfunction

endpackage

// File: rtl/core/pfr_div.sv
// pfr_div: restoring divider, one quotient bit per cycle
// gives quotient and remainder of an unsigned dividend by an unsigned divisor
// depends on nothing
module pfr_div #(
    parameter int DW = 16,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [VW:0]   part;
    logic [VW:0]   diff;
    logic          ge;

    // trial subtract of the shifted partial remainder
    assign part = {rem_reg, quo_reg[DW-1]};
    assign diff = part - {1'b0, dvs_reg};
    assign ge   = part >= {1'b0, dvs_reg};

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[VW-1:0] : part[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/pfr_scan.sv
// pfr_scan: frame table memory with clearing pass, per-item scan and fill write
// the scan finds hit, highest free frame and victim, and ages occupied frames
// depends on pfr_pkg
module pfr_scan #(
    parameter int MAX_FRAMES = pfr_pkg::MAX_FRAMES_DEF,
    parameter int PID_W      = 3,
    parameter int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    parameter int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pfr_pkg::scan_ctrl_t ctrl,
    input  logic [CNT_W-1:0]   n_eff,
    input  logic [15:0]        page,
    input  logic [PID_W-1:0]   pid,
    input  logic [31:0]        cur_time,
    input  logic [FRAME_W-1:0] target_frame,
    input  logic [FRAME_W-1:0] fill_frame,
    output pfr_pkg::scan_stat_t stat,
    output logic [FRAME_W-1:0] hit_frame,
    output logic [FRAME_W-1:0] free_frame,
    output logic [FRAME_W-1:0] victim_frame,
    output logic [15:0]        victim_page,
    output logic [PID_W-1:0]   victim_owner,
    output logic [31:0]        victim_res
);

    typedef struct packed {
        logic             occ;
        logic [15:0]      page;
        logic [PID_W-1:0] owner;
        logic [31:0]      res;
        logic [31:0]      last_use;
    } frame_entry_t;

    frame_entry_t mem [MAX_FRAMES];

    logic               clr_busy_reg;
    logic [FRAME_W-1:0] clr_idx_reg;
    logic               iss_busy_reg;
    logic [FRAME_W-1:0] rd_idx_reg;
    logic               pv_reg;
    logic [FRAME_W-1:0] p_idx_reg;
    frame_entry_t       q_reg;
    logic               use_lru_reg;
    logic               done_reg;
    logic               hit_reg;
    logic [FRAME_W-1:0] hit_idx_reg;
    logic               free_reg;
    logic [FRAME_W-1:0] free_idx_reg;
    logic [31:0]        best_time_reg;
    logic [FRAME_W-1:0] vic_idx_reg;
    logic [15:0]        vic_page_reg;
    logic [PID_W-1:0]   vic_owner_reg;
    logic [31:0]        vic_res_reg;

    logic               rd_last;
    logic               p_last;
    logic               match;
    logic               first_hit;
    logic               take;
    logic               mem_we;
    logic [FRAME_W-1:0] mem_waddr;
    frame_entry_t       mem_wdata;
    frame_entry_t       aged;

    // last index of the scan
    assign rd_last = ((CNT_W + 1)'(rd_idx_reg) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(n_eff);
    assign p_last  = ((CNT_W + 1)'(p_idx_reg) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(n_eff);

    // per-entry checks on the entry just read
    assign match     = q_reg.occ && (q_reg.page == page) && (q_reg.owner == pid);
    assign first_hit = pv_reg && match && !hit_reg;
    assign take      = use_lru_reg ? ((p_idx_reg == '0) || (q_reg.last_use < best_time_reg))
                                   : (p_idx_reg == target_frame);

    // aged copy of the entry for write back
    always_comb
    begin
        aged = q_reg;
        if (q_reg.occ)
        begin
            aged.res = pfr_pkg::sat_add(q_reg.res, 32'd1);
        end
        if (first_hit)
        begin
            aged.last_use = cur_time;
        end
    end

    // write port select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = fill_frame;
        mem_wdata = '{occ: 1'b1, page: page, owner: pid, res: 32'd1, last_use: cur_time};
        priority if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (pv_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = p_idx_reg;
            mem_wdata = aged;
        end
        else if (ctrl.fill)
        begin
            mem_we = 1'b1;
        end
    end

    // frame memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (iss_busy_reg)
        begin
            q_reg <= mem[rd_idx_reg];
        end
    end

    // clearing pass and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            iss_busy_reg <= 1'b0;
            rd_idx_reg   <= '0;
            pv_reg       <= 1'b0;
            p_idx_reg    <= '0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            use_lru_reg  <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == FRAME_W'(MAX_FRAMES - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            done_reg  <= pv_reg && p_last;
            pv_reg    <= iss_busy_reg;
            p_idx_reg <= rd_idx_reg;
            if (ctrl.start)
            begin
                iss_busy_reg <= 1'b1;
                rd_idx_reg   <= '0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
                use_lru_reg  <= ctrl.use_lru;
            end
            else
            begin
                if (iss_busy_reg)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    if (rd_last)
                    begin
                        iss_busy_reg <= 1'b0;
                    end
                end
                if (first_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (pv_reg && !q_reg.occ)
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    // captured frame indexes and victim contents
    always_ff @(posedge clk)
    begin
        if (first_hit)
        begin
            hit_idx_reg <= p_idx_reg;
        end
        if (pv_reg && !q_reg.occ)
        begin
            free_idx_reg <= p_idx_reg;
        end
        if (pv_reg && take)
        begin
            best_time_reg <= q_reg.last_use;
            vic_idx_reg   <= p_idx_reg;
            vic_page_reg  <= q_reg.page;
            vic_owner_reg <= q_reg.owner;
            vic_res_reg   <= q_reg.res;
        end
    end

    assign stat.clear_busy = clr_busy_reg;
    assign stat.done       = done_reg;
    assign stat.hit        = hit_reg;
    assign stat.free_found = free_reg;
    assign hit_frame       = hit_idx_reg;
    assign free_frame      = free_idx_reg;
    assign victim_frame    = vic_idx_reg;
    assign victim_page     = vic_page_reg;
    assign victim_owner    = vic_owner_reg;
    assign victim_res      = vic_res_reg;

endmodule

// File: rtl/core/page_frame_replacement_top.sv
// page_frame_replacement_top: demand paging frame table with selectable replacement
// sequencer, configuration registers, per-process counter memory and result register
// depends on pfr_pkg, pfr_div, pfr_scan
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one memory reference item per access.
//   out channel (out_valid/out_ready/out_data) gives one result item per reference.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes policy, frame count and
//   page size; cfg_ready is always high. The user must write only while the block is
//   idle; the block itself does not enforce it. A result passes the divider state
//   (bit-serial division of page number and victim index side by side), one pass
//   through the frame memory over the frames in use, then read-modify-write on the
//   process counter memory (for the requester, and on an eviction for the victim
//   owner) and the result load.
//   One item is worked on at a time; in_ready is high only while the sequencer is idle.
//   The result sits in an output register, so the next item is accepted while it
//   waits; a finished item waits only if the previous result has not been taken.
//   After reset, a clearing pass over all MAX_FRAMES frames (and all MAX_PROCESSES entries
//   of the counter memory, run in parallel) empties the frame table before the first item is taken.
module page_frame_replacement_top #(
    parameter int MAX_FRAMES    = pfr_pkg::MAX_FRAMES_DEF,
    parameter int MAX_PROCESSES = pfr_pkg::MAX_PROCS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pfr_pkg::ref_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pfr_pkg::result_item_t out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W   = (CNT_W > 7) ? CNT_W : 7;
    localparam int PID_W   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_DIV    = 9'b000000100,
        ST_SCAN   = 9'b000001000,
        ST_FILL   = 9'b000010000,
        ST_PID    = 9'b000100000,
        ST_OWN_RD = 9'b001000000,
        ST_OWN    = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [31:0] faults;
        logic [31:0] evictions;
        logic [31:0] res_sum;
    } proc_entry_t;

    proc_entry_t pmem [MAX_PROCESSES];

    state_t              state_reg, state_next;
    logic [1:0]          policy_reg;
    logic [6:0]          frames_reg;
    logic [15:0]         page_words_reg;
    logic [31:0]         time_reg;
    logic [FRAME_W-1:0]  last_filled_reg;
    logic [PID_W-1:0]    pid_reg;
    logic                hit_reg;
    logic                evicted_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [31:0]         faults_reg;
    logic [31:0]         vev_reg;
    logic [31:0]         vtot_reg;
    logic                pclr_busy_reg;
    logic [PID_W-1:0]    pclr_idx_reg;
    proc_entry_t         pq_reg;
    logic                out_valid_reg;
    pfr_pkg::result_item_t out_data_reg;

    logic                accept;
    logic [CMP_W-1:0]    fr_ext;
    logic [CMP_W-1:0]    n_cmp;
    logic [CNT_W-1:0]    n_eff;
    logic [15:0]         page_div;
    logic [30:0]         mod_dvd;
    logic                page_busy;
    logic                mod_busy;
    logic [15:0]         page_num;
    logic [15:0]         page_rem;
    logic [30:0]         mod_quo;
    logic [CNT_W-1:0]    mod_rem;
    logic [FRAME_W-1:0]  target_frame;
    logic [FRAME_W-1:0]  frame_sel;
    pfr_pkg::scan_ctrl_t scan_ctrl;
    pfr_pkg::scan_stat_t scan_stat;
    logic [FRAME_W-1:0]  hit_frame;
    logic [FRAME_W-1:0]  free_frame;
    logic [FRAME_W-1:0]  victim_frame;
    logic [15:0]         victim_page;
    logic [PID_W-1:0]    victim_owner;
    logic [31:0]         victim_res;
    logic                p_re;
    logic [PID_W-1:0]    p_raddr;
    logic                p_we;
    logic [PID_W-1:0]    p_waddr;
    proc_entry_t         p_wdata;
    logic                out_load;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // frame count in use, clamped to 1..MAX_FRAMES
    assign fr_ext = CMP_W'(frames_reg);
    always_comb
    begin
        priority if (fr_ext == '0)
        begin
            n_cmp = CMP_W'(1);
        end
        else if (fr_ext > CMP_W'(MAX_FRAMES))
        begin
            n_cmp = CMP_W'(MAX_FRAMES);
        end
        else
        begin
            n_cmp = fr_ext;
        end
    end
    assign n_eff = CNT_W'(n_cmp);

    // divider operands
    assign page_div = (page_words_reg == '0) ? 16'd1 : page_words_reg;
    assign mod_dvd  = (policy_reg == pfr_pkg::POL_RANDOM) ? in_data.random_value
                                                          : 31'(last_filled_reg);

    pfr_div #(.DW(16), .VW(16)) u_page_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (in_data.word_address),
        .divisor   (page_div),
        .busy      (page_busy),
        .quotient  (page_num),
        .remainder (page_rem)
    );

    pfr_div #(.DW(31), .VW(CNT_W)) u_mod_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (mod_dvd),
        .divisor   (n_eff),
        .busy      (mod_busy),
        .quotient  (mod_quo),
        .remainder (mod_rem)
    );

    // fixed victim index for random and last-filled policies, frame 0 otherwise
    assign target_frame = ((policy_reg == pfr_pkg::POL_RANDOM) ||
                           (policy_reg == pfr_pkg::POL_LAST)) ? FRAME_W'(mod_rem) : '0;

    // frame chosen once the scan is over
    assign frame_sel = scan_stat.hit        ? hit_frame :
                       scan_stat.free_found ? free_frame : victim_frame;

    assign scan_ctrl.start   = (state_reg == ST_DIV) && !page_busy && !mod_busy;
    assign scan_ctrl.use_lru = (policy_reg == pfr_pkg::POL_LRU);
    assign scan_ctrl.fill    = (state_reg == ST_FILL) && !scan_stat.hit;

    pfr_scan #(
        .MAX_FRAMES (MAX_FRAMES),
        .PID_W      (PID_W),
        .FRAME_W    (FRAME_W),
        .CNT_W      (CNT_W)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (scan_ctrl),
        .n_eff        (n_eff),
        .page         (page_num),
        .pid          (pid_reg),
        .cur_time     (time_reg),
        .target_frame (target_frame),
        .fill_frame   (frame_sel),
        .stat         (scan_stat),
        .hit_frame    (hit_frame),
        .free_frame   (free_frame),
        .victim_frame (victim_frame),
        .victim_page  (victim_page),
        .victim_owner (victim_owner),
        .victim_res   (victim_res)
    );

    // process counter memory ports
    assign p_re    = (state_reg == ST_FILL) || (state_reg == ST_OWN_RD);
    assign p_raddr = (state_reg == ST_OWN_RD) ? victim_owner : pid_reg;

    always_comb
    begin
        p_we    = 1'b0;
        p_waddr = pid_reg;
        p_wdata = pq_reg;
        priority if (pclr_busy_reg)
        begin
            p_we    = 1'b1;
            p_waddr = pclr_idx_reg;
            p_wdata = '0;
        end
        else if (state_reg == ST_PID)
        begin
            p_we           = 1'b1;
            p_wdata.faults = hit_reg ? pq_reg.faults : pfr_pkg::sat_add(pq_reg.faults, 32'd1);
        end
        else if (state_reg == ST_OWN)
        begin
            p_we              = 1'b1;
            p_waddr           = victim_owner;
            p_wdata.evictions = pfr_pkg::sat_add(pq_reg.evictions, 32'd1);
            p_wdata.res_sum   = pfr_pkg::sat_add(pq_reg.res_sum, victim_res);
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pmem[p_waddr] <= p_wdata;
        end
        if (p_re)
        begin
            pq_reg <= pmem[p_raddr];
        end
    end

    // sequencer
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!pclr_busy_reg && !scan_stat.clear_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (scan_ctrl.start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                state_next = ST_PID;
            end
            ST_PID:
            begin
                state_next = evicted_reg ? ST_OWN_RD : ST_OUT;
            end
            ST_OWN_RD:
            begin
                state_next = ST_OWN;
            end
            ST_OWN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            policy_reg      <= pfr_pkg::POLICY_RST;
            frames_reg      <= pfr_pkg::FRAMES_RST;
            page_words_reg  <= pfr_pkg::PAGE_WORDS_RST;
            time_reg        <= '0;
            last_filled_reg <= '0;
            pclr_busy_reg   <= 1'b1;
            pclr_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    pfr_pkg::CFG_POLICY: policy_reg     <= cfg_data[1:0];
                    pfr_pkg::CFG_FRAMES: frames_reg     <= cfg_data[6:0];
                    pfr_pkg::CFG_PAGE:   page_words_reg <= cfg_data;
                    default:             ;
                endcase
            end
            if (pclr_busy_reg)
            begin
                pclr_idx_reg <= pclr_idx_reg + 1'b1;
                if (pclr_idx_reg == PID_W'(MAX_PROCESSES - 1))
                begin
                    pclr_busy_reg <= 1'b0;
                end
            end
            if (scan_ctrl.fill)
            begin
                last_filled_reg <= frame_sel;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                time_reg      <= pfr_pkg::sat_add(time_reg, 32'd1);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pid_reg <= PID_W'(pfr_pkg::pid_wrap(in_data.process_id, MAX_PROCESSES));
        end
        if (state_reg == ST_FILL)
        begin
            hit_reg     <= scan_stat.hit;
            evicted_reg <= !scan_stat.hit && !scan_stat.free_found;
            frame_reg   <= frame_sel;
        end
        if (state_reg == ST_PID)
        begin
            faults_reg <= p_wdata.faults;
            vev_reg    <= '0;
            vtot_reg   <= '0;
        end
        if (state_reg == ST_OWN)
        begin
            vev_reg  <= p_wdata.evictions;
            vtot_reg <= p_wdata.res_sum;
        end
        if (out_load)
        begin
            out_data_reg.hit                    <= hit_reg;
            out_data_reg.frame_used             <= 6'(frame_reg);
            out_data_reg.evicted                <= evicted_reg;
            out_data_reg.victim_process         <= evicted_reg ? 3'(victim_owner) : 3'd0;
            out_data_reg.victim_page            <= evicted_reg ? victim_page : 16'd0;
            out_data_reg.victim_residency       <= evicted_reg ? victim_res : 32'd0;
            out_data_reg.requester_faults       <= faults_reg;
            out_data_reg.victim_evictions       <= vev_reg;
            out_data_reg.victim_residency_total <= vtot_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/core/pfr_checker.sv
// pfr_checker: port-level assertions for the page frame replacement block
// bound to page_frame_replacement_top; depends on pfr_pkg
module pfr_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input pfr_pkg::result_item_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while another is in work");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.hit && out_data.evicted))
        else $error("hit with eviction");

    // victim fields are zero without an eviction
    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.evicted |-> (out_data.victim_evictions == 32'd0) &&
        (out_data.victim_residency_total == 32'd0) && (out_data.victim_page == 16'd0))
        else $error("victim fields set without eviction");

    // an eviction or a miss counts at least once
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> (out_data.requester_faults != 32'd0) &&
        (!out_data.evicted || (out_data.victim_evictions != 32'd0)))
        else $error("miss or eviction not counted");

endmodule

bind page_frame_replacement_top pfr_checker u_pfr_checker (.*);
